// ===== hw/rtl/ffha_pkg.sv =====
// types, codes and constants shared by the heap allocator modules
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int POS_W  = 18;
   localparam int SIZE_W = 16;
   localparam int HDR_BYTES = 16;

   typedef enum logic [1:0] {
      TAG_NONE = 2'd0,
      TAG_FREE = 2'd1,
      TAG_USED = 2'd2
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [SIZE_W-1:0]   size;
   } entry_type;

   typedef enum logic [2:0] {
      ST_ALLOCATED      = 3'd0,
      ST_NO_MEMORY      = 3'd1,
      ST_ZERO_SIZE      = 3'd2,
      ST_RELEASED       = 3'd3,
      ST_OUT_OF_RANGE   = 3'd4,
      ST_DOUBLE_RELEASE = 3'd5,
      ST_NOT_HEADER     = 3'd6
   } status_type;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_START,
      CMD_READ_POS,
      CMD_STEP_POS,
      CMD_SPLIT_WR,
      CMD_MARK_USED,
      CMD_READ_HP,
      CMD_HOLD_H,
      CMD_READ_NX,
      CMD_MERGE,
      CMD_WR_H,
      CMD_READ_CUR,
      CMD_STEP_CUR,
      CMD_WR_PREV
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       load_rsp;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic op_release;
      logic zero_size;
      logic off_range;
      logic unaligned;
      logic pos_end;
      logic fit;
      logic split_ok;
      logic tag_free;
      logic tag_used;
      logic nx_end;
      logic cur_done;
      logic prev_merge;
   } dp_flags_type;

endpackage

// ===== hw/rtl/first_fit_heap_allocator_unit.sv =====
// top level of the first-fit heap allocator: controller, datapath and checks
`timescale 1ns / 1ps
// First-fit allocator over an arena of ARENA_BYTES bytes, kept as an implicit list
// of 16-byte headers in an on-chip header memory (one entry per 8-byte granule).
// After reset a clearing pass writes every header entry, and no request is taken
// until it ends. Each request runs alone: an allocate visits blocks in turn until one
// fits; a release merges each free following block, then walks every block that lies
// before the freed one (the predecessor search walks from the arena start). Rate
// is set by the single-port header memory, one read per visited block. The result
// register lets a request be accepted while the previous response waits.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
   parameter int ARENA_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_request_size,
   input  logic [16:0] req_release_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_alloc_offset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   dp_cmd_type   cmd;
   dp_flags_type flags;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   ffha_dp #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .flags              (flags),
      .req_operation      (req_operation),
      .req_request_size   (req_request_size),
      .req_release_offset (req_release_offset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_status         (rsp_status),
      .rsp_alloc_offset   (rsp_alloc_offset)
   );

   // one request in flight: the port closes right after an accept
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in progress");

   // only a granted block carries an offset
   a_offset_only_on_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_ALLOCATED)) |-> (rsp_alloc_offset == 16'd0))
      else $error("nonzero offset on a response that grants nothing");

   // a response rises only after a load of the result register
   a_rsp_after_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("response raised without a load");

endmodule

// ===== hw/rtl/ffha_dp.sv =====
// datapath: header memory, walk pointers, size arithmetic and result register
`timescale 1ns / 1ps
module ffha_dp import ffha_pkg::*; #(
   parameter int ARENA_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_flags_type       flags,
   input  logic               req_operation,
   input  logic [15:0]        req_request_size,
   input  logic [16:0]        req_release_offset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_alloc_offset
);

   localparam int GRANULES = (ARENA_BYTES + 7) / 8;
   localparam int GRAN_W = $clog2(GRANULES);
   localparam logic [POS_W-1:0] ARENA_POS = POS_W'(ARENA_BYTES);
   localparam logic [POS_W-1:0] HDR_POS = POS_W'(HDR_BYTES);
   localparam logic [SIZE_W-1:0] FIRST_SIZE = SIZE_W'(ARENA_BYTES - HDR_BYTES);
   localparam logic [GRAN_W-1:0] LAST_GRAN = GRAN_W'(GRANULES - 1);

   entry_type mem [GRANULES];
   entry_type rdata_ff;

   logic [GRAN_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0]        min_split_ff;
   logic              op_ff;
   logic [POS_W-1:0]  req_size_ff, off_ff;
   logic [POS_W-1:0]  need_ff, pos_ff, hp_ff, nx_ff, cur_ff, prev_ff, hsize_ff;
   logic [POS_W-1:0]  need_in, pos_in, hp_in, nx_in, cur_in, prev_in, hsize_in;
   logic [SIZE_W-1:0] prev_size_ff, prev_size_in;
   logic              prev_free_ff, prev_free_in, have_prev_ff, have_prev_in;
   logic [2:0]        rsp_status_ff;
   logic [15:0]       rsp_offset_ff;

   logic [POS_W-1:0]  rsize, sp, merged;
   logic              fits_split, mem_we, mem_re;
   logic [POS_W-1:0]  maddr;
   entry_type         wdata;

   assign rsize  = POS_W'(rdata_ff.size);
   assign sp     = pos_ff + HDR_POS + need_ff;
   assign merged = hsize_ff + HDR_POS + rsize;
   assign fits_split = (rsize >= need_ff + HDR_POS + POS_W'(min_split_ff)) && (sp < ARENA_POS);

   always_comb begin
      flags.clr_last   = (clr_cnt_ff == LAST_GRAN);
      flags.op_release = (op_ff == OP_RELEASE);
      flags.zero_size  = (req_size_ff == '0);
      flags.off_range  = (off_ff < HDR_POS) || (hp_ff >= ARENA_POS);
      flags.unaligned  = (hp_ff[2:0] != 3'd0);
      flags.pos_end    = (pos_ff >= ARENA_POS);
      flags.fit        = (rdata_ff.tag == TAG_FREE) && (rsize >= need_ff);
      flags.split_ok   = fits_split;
      flags.tag_free   = (rdata_ff.tag == TAG_FREE);
      flags.tag_used   = (rdata_ff.tag == TAG_USED);
      flags.nx_end     = (nx_ff >= ARENA_POS);
      flags.cur_done   = (cur_ff >= ARENA_POS) || (cur_ff == hp_ff);
      flags.prev_merge = have_prev_ff && prev_free_ff;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      maddr  = '0;
      wdata  = '{tag: TAG_NONE, size: '0};
      case (cmd.op)
         CMD_CLEAR: begin
            mem_we = 1'b1;
            maddr  = POS_W'({clr_cnt_ff, 3'b000});
            if (clr_cnt_ff == '0) begin
               wdata = '{tag: TAG_FREE, size: FIRST_SIZE};
            end
         end
         CMD_READ_POS: begin
            mem_re = 1'b1;
            maddr  = pos_ff;
         end
         CMD_SPLIT_WR: begin
            mem_we = 1'b1;
            maddr  = sp;
            wdata  = '{tag: TAG_FREE, size: SIZE_W'(rsize - need_ff - HDR_POS)};
         end
         CMD_MARK_USED: begin
            mem_we = 1'b1;
            maddr  = pos_ff;
            wdata  = '{tag: TAG_USED,
                       size: fits_split ? SIZE_W'(need_ff) : rdata_ff.size};
         end
         CMD_READ_HP: begin
            mem_re = 1'b1;
            maddr  = hp_ff;
         end
         CMD_READ_NX: begin
            mem_re = 1'b1;
            maddr  = nx_ff;
         end
         CMD_WR_H: begin
            mem_we = 1'b1;
            maddr  = hp_ff;
            wdata  = '{tag: TAG_FREE, size: SIZE_W'(hsize_ff)};
         end
         CMD_READ_CUR: begin
            mem_re = 1'b1;
            maddr  = cur_ff;
         end
         CMD_WR_PREV: begin
            mem_we = 1'b1;
            maddr  = prev_ff;
            wdata  = '{tag: TAG_FREE,
                       size: SIZE_W'(POS_W'(prev_size_ff) + HDR_POS + hsize_ff)};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[maddr[GRAN_W+2:3]] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[maddr[GRAN_W+2:3]];
      end
   end

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      need_in      = need_ff;
      pos_in       = pos_ff;
      hp_in        = hp_ff;
      nx_in        = nx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      hsize_in     = hsize_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      have_prev_in = have_prev_ff;
      case (cmd.op)
         CMD_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + GRAN_W'(1);
         end
         CMD_START: begin
            need_in      = (POS_W'(req_request_size) + POS_W'(7)) & ~POS_W'(7);
            pos_in       = '0;
            hp_in        = POS_W'(req_release_offset) - HDR_POS;
            cur_in       = '0;
            have_prev_in = 1'b0;
            prev_free_in = 1'b0;
         end
         CMD_STEP_POS: begin
            pos_in = pos_ff + HDR_POS + rsize;
         end
         CMD_HOLD_H: begin
            hsize_in = rsize;
            nx_in    = hp_ff + HDR_POS + rsize;
         end
         CMD_MERGE: begin
            hsize_in = merged;
            nx_in    = hp_ff + HDR_POS + merged;
         end
         CMD_STEP_CUR: begin
            prev_in      = cur_ff;
            prev_size_in = rdata_ff.size;
            prev_free_in = (rdata_ff.tag == TAG_FREE);
            have_prev_in = 1'b1;
            cur_in       = cur_ff + HDR_POS + rsize;
         end
         default: begin
            clr_cnt_in = clr_cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         min_split_ff <= 8'd16;
         have_prev_ff <= 1'b0;
         prev_free_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         have_prev_ff <= have_prev_in;
         prev_free_ff <= prev_free_in;
         if (csr_write_enable) begin
            min_split_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff      <= need_in;
      pos_ff       <= pos_in;
      hp_ff        <= hp_in;
      nx_ff        <= nx_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      hsize_ff     <= hsize_in;
      prev_size_ff <= prev_size_in;
      if (cmd.op == CMD_START) begin
         op_ff       <= req_operation;
         req_size_ff <= POS_W'(req_request_size);
         off_ff      <= POS_W'(req_release_offset);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.code;
         rsp_offset_ff <= (cmd.code == ST_ALLOCATED) ? 16'(pos_ff + HDR_POS) : 16'd0;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_offset_ff;

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// controller: sequences clearing, list walks, splits, merges and the response
`timescale 1ns / 1ps
module ffha_ctrl import ffha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dp_flags_type flags,
   output dp_cmd_type   cmd
);

   typedef enum logic [15:0] {
      S_CLEAR = 16'h0001,
      S_IDLE  = 16'h0002,
      S_DISP  = 16'h0004,
      S_A_RD  = 16'h0008,
      S_A_EV  = 16'h0010,
      S_A_SPL = 16'h0020,
      S_A_MRK = 16'h0040,
      S_R_RD  = 16'h0080,
      S_R_EV  = 16'h0100,
      S_R_NRD = 16'h0200,
      S_R_NEV = 16'h0400,
      S_R_HWR = 16'h0800,
      S_R_BRD = 16'h1000,
      S_R_BEV = 16'h2000,
      S_R_PWR = 16'h4000,
      S_RESP  = 16'h8000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cmd.op       = CMD_NONE;
      cmd.load_rsp = 1'b0;
      cmd.code     = code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = CMD_CLEAR;
            if (flags.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_START;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!flags.op_release) begin
               if (flags.zero_size) begin
                  code_in  = ST_ZERO_SIZE;
                  state_in = S_RESP;
               end else begin
                  state_in = S_A_RD;
               end
            end else if (flags.off_range) begin
               code_in  = ST_OUT_OF_RANGE;
               state_in = S_RESP;
            end else if (flags.unaligned) begin
               code_in  = ST_NOT_HEADER;
               state_in = S_RESP;
            end else begin
               state_in = S_R_RD;
            end
         end
         S_A_RD: begin
            if (flags.pos_end) begin
               code_in  = ST_NO_MEMORY;
               state_in = S_RESP;
            end else begin
               cmd.op   = CMD_READ_POS;
               state_in = S_A_EV;
            end
         end
         S_A_EV: begin
            if (flags.fit) begin
               state_in = flags.split_ok ? S_A_SPL : S_A_MRK;
            end else begin
               cmd.op   = CMD_STEP_POS;
               state_in = S_A_RD;
            end
         end
         S_A_SPL: begin
            cmd.op   = CMD_SPLIT_WR;
            state_in = S_A_MRK;
         end
         S_A_MRK: begin
            cmd.op   = CMD_MARK_USED;
            code_in  = ST_ALLOCATED;
            state_in = S_RESP;
         end
         S_R_RD: begin
            cmd.op   = CMD_READ_HP;
            state_in = S_R_EV;
         end
         S_R_EV: begin
            if (flags.tag_free) begin
               code_in  = ST_DOUBLE_RELEASE;
               state_in = S_RESP;
            end else if (!flags.tag_used) begin
               code_in  = ST_NOT_HEADER;
               state_in = S_RESP;
            end else begin
               cmd.op   = CMD_HOLD_H;
               state_in = S_R_NRD;
            end
         end
         S_R_NRD: begin
            if (flags.nx_end) begin
               state_in = S_R_HWR;
            end else begin
               cmd.op   = CMD_READ_NX;
               state_in = S_R_NEV;
            end
         end
         S_R_NEV: begin
            if (flags.tag_free) begin
               cmd.op   = CMD_MERGE;
               state_in = S_R_NRD;
            end else begin
               state_in = S_R_HWR;
            end
         end
         S_R_HWR: begin
            cmd.op   = CMD_WR_H;
            state_in = S_R_BRD;
         end
         S_R_BRD: begin
            // walk from the arena start to find the block just before the freed one
            if (flags.cur_done) begin
               if (flags.prev_merge) begin
                  state_in = S_R_PWR;
               end else begin
                  code_in  = ST_RELEASED;
                  state_in = S_RESP;
               end
            end else begin
               cmd.op   = CMD_READ_CUR;
               state_in = S_R_BEV;
            end
         end
         S_R_BEV: begin
            cmd.op   = CMD_STEP_CUR;
            state_in = S_R_BRD;
         end
         S_R_PWR: begin
            cmd.op   = CMD_WR_PREV;
            code_in  = ST_RELEASED;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         code_ff      <= ST_ALLOCATED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== tb/sv/tb_first_fit_heap_allocator_unit.sv =====
// self-checking testbench for the first-fit heap allocator unit
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_unit;
   import ffha_pkg::*;

   localparam int ARENA      = 65536;
   localparam int GRANULES   = ARENA / 8;
   localparam int IDLE_LIMIT = 60000;

   typedef enum int {KIND_ALLOC, KIND_REL_LIVE, KIND_REL_FREED, KIND_RAW} kind_type;

   typedef struct {
      kind_type    kind;
      logic        op;
      logic [15:0] size;
      logic [16:0] off;
      bit          drain;
   } request_type;

   typedef struct {
      status_type  st;
      logic [15:0] ofs;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [15:0] req_request_size;
   logic [16:0] req_release_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_alloc_offset;
   logic        csr_write_enable;
   logic [7:0]  csr_write_data;

   first_fit_heap_allocator_unit #(.ARENA_BYTES(ARENA)) u_top (.*);

   // heap image kept by the testbench
   tag_type     heap_tag [GRANULES];
   int unsigned blk_bytes [GRANULES];
   int unsigned split_floor;

   request_type request_q[$];
   outcome_type outcome_q[$];
   int unsigned live_q[$];
   int unsigned freed_q[$];

   int  errors;
   int  idle_cycles;
   bit  calm;
   bit  hold_start;
   int  send_gap;
   int  stall_cnt;
   int  hold_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned next_block(int unsigned pos);
      return pos + HDR_BYTES + blk_bytes[pos >> 3];
   endfunction

   function automatic outcome_type heap_apply(logic op, logic [15:0] req, logic [16:0] off);
      outcome_type r;
      int unsigned need, pos, hp, nx, cur, prev, sp;
      bit have_prev;
      r.st  = ST_ALLOCATED;
      r.ofs = '0;
      if (op == OP_ALLOCATE) begin
         if (req == 0) begin
            r.st = ST_ZERO_SIZE;
            return r;
         end
         need = (req + 7) & ~32'd7;
         pos = 0;
         while (pos < ARENA) begin
            if (heap_tag[pos >> 3] == TAG_FREE && blk_bytes[pos >> 3] >= need) begin
               if (blk_bytes[pos >> 3] >= need + HDR_BYTES + split_floor) begin
                  sp = pos + HDR_BYTES + need;
                  if (sp < ARENA) begin
                     heap_tag[sp >> 3]  = TAG_FREE;
                     blk_bytes[sp >> 3] = blk_bytes[pos >> 3] - need - HDR_BYTES;
                     blk_bytes[pos >> 3] = need;
                  end
               end
               heap_tag[pos >> 3] = TAG_USED;
               r.ofs = 16'(pos + HDR_BYTES);
               return r;
            end
            pos = next_block(pos);
         end
         r.st = ST_NO_MEMORY;
         return r;
      end
      if (off < HDR_BYTES || off - HDR_BYTES >= ARENA) begin
         r.st = ST_OUT_OF_RANGE;
         return r;
      end
      hp = off - HDR_BYTES;
      if ((hp & 7) != 0 || heap_tag[hp >> 3] == TAG_NONE) begin
         r.st = ST_NOT_HEADER;
         return r;
      end
      if (heap_tag[hp >> 3] == TAG_FREE) begin
         r.st = ST_DOUBLE_RELEASE;
         return r;
      end
      heap_tag[hp >> 3] = TAG_FREE;
      nx = next_block(hp);
      while (nx < ARENA && heap_tag[nx >> 3] == TAG_FREE) begin
         blk_bytes[hp >> 3] += HDR_BYTES + blk_bytes[nx >> 3];
         nx = next_block(hp);
      end
      // predecessor search from the arena start
      cur = 0;
      prev = 0;
      have_prev = 0;
      while (cur < ARENA && cur != hp) begin
         prev = cur;
         have_prev = 1;
         cur = next_block(cur);
      end
      if (have_prev && heap_tag[prev >> 3] == TAG_FREE)
         blk_bytes[prev >> 3] += HDR_BYTES + blk_bytes[hp >> 3];
      r.st = ST_RELEASED;
      return r;
   endfunction

   // sender
   always @(posedge clock) begin
      logic        nv;
      request_type it;
      outcome_type o;
      int          k;
      if (reset) begin
         req_valid <= 1'b0;
         req_operation <= OP_ALLOCATE;
         req_request_size <= '0;
         req_release_offset <= '0;
         send_gap = 0;
      end else begin
         nv = req_valid;
         if (req_valid && !req_stall) begin
            o = heap_apply(req_operation, req_request_size, req_release_offset);
            outcome_q.push_back(o);
            if (req_operation == OP_ALLOCATE && o.st == ST_ALLOCATED)
               live_q.push_back(o.ofs);
            nv = 1'b0;
            send_gap = calm ? 0 : $urandom_range(0, 5);
         end
         if (!nv) begin
            if (send_gap > 0)
               send_gap--;
            else if (request_q.size() > 0 && !(request_q[0].drain && outcome_q.size() != 0)) begin
               it = request_q.pop_front();
               if (it.kind == KIND_REL_LIVE && live_q.size() > 0) begin
                  k = $urandom_range(0, live_q.size() - 1);
                  it.off = 17'(live_q[k]);
                  live_q.delete(k);
                  freed_q.push_back(it.off);
               end else if (it.kind == KIND_REL_FREED && freed_q.size() > 0) begin
                  it.off = 17'(freed_q[$urandom_range(0, freed_q.size() - 1)]);
               end
               req_operation <= it.op;
               req_request_size <= it.size;
               req_release_offset <= it.off;
               nv = 1'b1;
            end
         end
         req_valid <= nv;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_cnt = 0;
         hold_cnt = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected response status %0d offset %0d", rsp_status, rsp_alloc_offset);
               errors++;
            end else begin
               e = outcome_q.pop_front();
               if (rsp_status !== e.st) begin
                  $error("status expected %0d actual %0d", e.st, rsp_status);
                  errors++;
               end
               if (rsp_alloc_offset !== e.ofs) begin
                  $error("alloc_offset expected %0d actual %0d", e.ofs, rsp_alloc_offset);
                  errors++;
               end
            end
            stall_cnt = calm ? 0 : $urandom_range(0, 5);
         end
         if (hold_start) begin
            hold_start = 0;
            hold_cnt = 600;
         end
         rsp_stall <= (stall_cnt > 0) || (hold_cnt > 0);
         if (stall_cnt > 0) stall_cnt--;
         if (hold_cnt > 0) hold_cnt--;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic push_request(kind_type kind, logic op, int unsigned size, int unsigned off);
      request_type it;
      it.kind = kind;
      it.op = op;
      it.size = 16'(size);
      it.off = 17'(off);
      it.drain = 0;
      request_q.push_back(it);
   endtask

   task automatic write_split_floor(logic [7:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      split_floor = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (request_q.size() > 0 || req_valid || outcome_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_random(int n);
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 58) begin
            r = $urandom_range(0, 19);
            if (r == 0)
               push_request(KIND_ALLOC, OP_ALLOCATE, $urandom_range(0, 65535), 0);
            else if (r < 6)
               push_request(KIND_ALLOC, OP_ALLOCATE, $urandom_range(1, 64), 0);
            else
               push_request(KIND_ALLOC, OP_ALLOCATE, $urandom_range(1, 4096), 0);
         end else if (r < 90)
            push_request(KIND_REL_LIVE, OP_RELEASE, $urandom_range(0, 65535), 16);
         else if (r < 94)
            push_request(KIND_REL_FREED, OP_RELEASE, $urandom_range(0, 65535), 16);
         else if (r < 97)
            push_request(KIND_RAW, OP_RELEASE, 0, 16 + 8 * $urandom_range(0, GRANULES - 1));
         else
            push_request(KIND_RAW, OP_RELEASE, 0, $urandom_range(0, 131071));
      end
   endtask

   initial begin
      logic [7:0] floors [5];
      floors = '{8'd16, 8'd0, 8'd255, 8'd40, 8'd16};
      errors = 0;
      calm = 0;
      hold_start = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ALLOCATE;
      req_request_size = '0;
      req_release_offset = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      for (int g = 0; g < GRANULES; g++) begin
         heap_tag[g] = TAG_NONE;
         blk_bytes[g] = 0;
      end
      heap_tag[0] = TAG_FREE;
      blk_bytes[0] = ARENA - HDR_BYTES;
      split_floor = 16;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         write_split_floor(floors[ph]);
         if (ph == 0) begin
            push_request(KIND_ALLOC, OP_ALLOCATE, 0, 0);
            push_request(KIND_ALLOC, OP_ALLOCATE, 65535, 0);
            push_request(KIND_ALLOC, OP_ALLOCATE, 65520, 0);
            push_request(KIND_ALLOC, OP_ALLOCATE, 1, 0);
            push_request(KIND_RAW, OP_RELEASE, 0, 16);
            push_request(KIND_RAW, OP_RELEASE, 0, 16);
            push_request(KIND_RAW, OP_RELEASE, 0, 0);
            push_request(KIND_RAW, OP_RELEASE, 0, 131071);
            push_request(KIND_RAW, OP_RELEASE, 0, 15);
            push_request(KIND_RAW, OP_RELEASE, 0, 65552);
            push_request(KIND_RAW, OP_RELEASE, 0, 17);
            push_request(KIND_RAW, OP_RELEASE, 0, 24);
            push_request(KIND_ALLOC, OP_ALLOCATE, 1, 0);
            push_request(KIND_ALLOC, OP_ALLOCATE, 8, 0);
            push_request(KIND_ALLOC, OP_ALLOCATE, 100, 0);
            push_request(KIND_RAW, OP_RELEASE, 0, 40);
            push_request(KIND_RAW, OP_RELEASE, 65535, 16);
            push_request(KIND_RAW, OP_RELEASE, 0, 64);
            push_request(KIND_RAW, OP_RELEASE, 0, 40);
            push_request(KIND_ALLOC, OP_ALLOCATE, 65535, 0);
            push_request(KIND_ALLOC, OP_ALLOCATE, 32768, 0);
            push_request(KIND_RAW, OP_RELEASE, 0, 65535);
            push_request(KIND_RAW, OP_RELEASE, 0, 65536);
         end
         // receiver holds off while the sender keeps offering requests
         if (ph == 1) hold_start = 1;
         calm = (ph == 3);
         push_random(110);
         if (ph == 2) begin
            push_request(KIND_ALLOC, OP_ALLOCATE, 24, 0);
            request_q[$].drain = 1;
         end
         push_random(110);
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_dp.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_unit.sv
tb/sv/tb_first_fit_heap_allocator_unit.sv
